// File: sv/fwdm_pkg.sv
// Shared types, constants and divider reciprocals of the four wheel drive mixer.
package fwdm_pkg;

	localparam int SINE_FRAC_BITS = 15;
	localparam int SIN_W          = SINE_FRAC_BITS + 1;
	localparam int TAYLOR_TERMS   = 6;
	localparam int LANE_LAT       = 5 + 2 * TAYLOR_TERMS;
	localparam int FIFO_DEPTH     = 32;
	localparam int PTR_W          = $clog2(FIFO_DEPTH);
	localparam int CNT_W          = PTR_W + 1;
	localparam int ANGLE_W        = 15;

	localparam int FULL_TURN      = 5760;
	localparam int HALF_TURN      = 2880;
	localparam int QUARTER_TURN   = 1440;
	localparam int EIGHTH_TURN    = 720;
	localparam int SPIN_OFFSET    = 70;

	localparam logic [30:0] Q30_ONE          = 31'h4000_0000;
	localparam logic [30:0] RAD_PER_UNIT_Q40 = 31'd1199381129;
	localparam logic [31:0] SINE_RND         = 32'd1 << (29 - SINE_FRAC_BITS);

	localparam logic [7:0] BASE_SPEED_RST = 8'd200;
	localparam logic [7:0] SPIN_SPEED_RST = 8'd100;

	// Register indexes, taken from paddr[2].
	localparam logic REG_BASE_SPEED = 1'b0;
	localparam logic REG_SPIN_SPEED = 1'b1;

	// Exact floor division of a 32-bit value by the series divisors:
	// q = (p * RECIP) >> RSHIFT with RECIP = ceil(2^RSHIFT / d).
	localparam logic [32:0] RECIP [TAYLOR_TERMS] = '{
		33'(((64'd1 << 40) + 64'd155) / 64'd156),
		33'(((64'd1 << 39) + 64'd109) / 64'd110),
		33'(((64'd1 << 39) + 64'd71) / 64'd72),
		33'(((64'd1 << 38) + 64'd41) / 64'd42),
		33'(((64'd1 << 37) + 64'd19) / 64'd20),
		33'(((64'd1 << 35) + 64'd5) / 64'd6)
	};
	localparam logic [5:0] RSHIFT [TAYLOR_TERMS] = '{
		6'd40, 6'd39, 6'd39, 6'd38, 6'd37, 6'd35
	};

	// Working set handed from one series cell to the next.
	typedef struct packed {
		logic        neg;
		logic [30:0] x;
		logic [31:0] x2;
		logic [30:0] t;
	} term_t;

	typedef struct packed {
		logic             neg;
		logic [SIN_W-1:0] mag;
	} sine_t;

	typedef struct packed {
		logic [3:0][7:0] duty;
		logic [3:0]      fwd;
	} res_t;

endpackage

// File: sv/fwdm_cmd_if.sv
// Command channel: drive mode, heading, rotation and orbit radius.
interface fwdm_cmd_if;
	logic              valid;
	logic              ready;
	logic              req_type;
	logic signed [13:0] heading;
	logic [1:0]        rotation;
	logic [7:0]        orbit_radius;

	modport source (output valid, req_type, heading, rotation, orbit_radius, input ready);
	modport sink (input valid, req_type, heading, rotation, orbit_radius, output ready);
endinterface

// File: sv/fwdm_res_if.sv
// Result channel: PWM magnitude and forward bit for each of the four wheels.
interface fwdm_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] duty_0;
	logic [7:0] duty_1;
	logic [7:0] duty_2;
	logic [7:0] duty_3;
	logic       fwd_0;
	logic       fwd_1;
	logic       fwd_2;
	logic       fwd_3;

	modport source (output valid, duty_0, duty_1, duty_2, duty_3,
		fwd_0, fwd_1, fwd_2, fwd_3, input ready);
	modport sink (input valid, duty_0, duty_1, duty_2, duty_3,
		fwd_0, fwd_1, fwd_2, fwd_3, output ready);
endinterface

// File: sv/four_wheel_drive_mixer.sv
// Top level of the four wheel drive mixer: sine lanes, wheel mixing and result queue.
//
//   port        role    carries
//   cmd         sink    req_type, heading, rotation, orbit_radius
//   res         source  duty_0..duty_3, fwd_0..fwd_3
//   APB         slave   base_speed at 0x0, spin_speed at 0x4
//
// One request is taken per cycle while cmd.ready is high; its result passes the sine lanes,
// whose length is set by six two-stage series cells, and a scaling register before the queue.
// Reset clears the pipeline valid bits and the queue, and loads 200 and 100 into the
// speed registers. The pipeline never stalls: cmd.ready falls only while 32 requests
// are accepted but not yet delivered, the size of the result queue.
module four_wheel_drive_mixer (
	input  logic               clk,
	input  logic               arst_n,
	fwdm_cmd_if.sink           cmd,
	fwdm_res_if.source         res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	typedef struct packed {
		logic       req_type;
		logic [1:0] rotation;
		logic [7:0] orbit_radius;
	} side_t;

	logic [7:0] base_speed_q;
	logic [7:0] spin_speed_q;
	logic       cfg_wr;

	logic signed [fwdm_pkg::ANGLE_W-1:0] head_ext;
	logic signed [fwdm_pkg::ANGLE_W-1:0] ang_m;
	logic signed [fwdm_pkg::ANGLE_W-1:0] ang_p;
	fwdm_pkg::sine_t sine_m;
	fwdm_pkg::sine_t sine_p;

	logic        accept;
	logic        pop;
	logic [fwdm_pkg::LANE_LAT-1:0] sb_valid_q;
	side_t       sb_q [fwdm_pkg::LANE_LAT];

	logic [fwdm_pkg::SIN_W+7:0] prod_m;
	logic [fwdm_pkg::SIN_W+7:0] prod_p;
	logic        valid_s18;
	logic [7:0]  mag_m_s18;
	logic [7:0]  mag_p_s18;
	logic        neg_m_s18;
	logic        neg_p_s18;
	side_t       side_s18;

	fwdm_pkg::res_t mix;
	fwdm_pkg::res_t fifo_q [fwdm_pkg::FIFO_DEPTH];
	fwdm_pkg::res_t rd_res;
	logic [fwdm_pkg::PTR_W:0] wr_ptr_q;
	logic [fwdm_pkg::PTR_W:0] rd_ptr_q;
	logic [fwdm_pkg::PTR_W:0] fill;
	logic [fwdm_pkg::CNT_W-1:0] cnt_q;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_speed_q <= fwdm_pkg::BASE_SPEED_RST;
			spin_speed_q <= fwdm_pkg::SPIN_SPEED_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				fwdm_pkg::REG_BASE_SPEED: base_speed_q <= pwdata[7:0];
				fwdm_pkg::REG_SPIN_SPEED: spin_speed_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			fwdm_pkg::REG_BASE_SPEED: prdata = {24'd0, base_speed_q};
			fwdm_pkg::REG_SPIN_SPEED: prdata = {24'd0, spin_speed_q};
			default:                  prdata = 32'd0;
		endcase
	end

	// The two sine angles are 45 degrees minus and plus the heading.
	assign head_ext = {cmd.heading[13], cmd.heading};
	assign ang_m    = fwdm_pkg::ANGLE_W'(fwdm_pkg::EIGHTH_TURN) - head_ext;
	assign ang_p    = fwdm_pkg::ANGLE_W'(fwdm_pkg::EIGHTH_TURN) + head_ext;

	fwdm_sine_lane u_lane_m (
		.clk  (clk),
		.angle(ang_m),
		.sine (sine_m)
	);

	fwdm_sine_lane u_lane_p (
		.clk  (clk),
		.angle(ang_p),
		.sine (sine_p)
	);

	assign cmd.ready = cnt_q < fwdm_pkg::CNT_W'(fwdm_pkg::FIFO_DEPTH);
	assign accept    = cmd.valid && cmd.ready;
	assign pop       = res.valid && res.ready;

	// Sideband line that runs alongside the sine lanes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sb_valid_q <= '0;
			valid_s18  <= 1'b0;
		end else begin
			sb_valid_q <= {sb_valid_q[fwdm_pkg::LANE_LAT-2:0], accept};
			valid_s18  <= sb_valid_q[fwdm_pkg::LANE_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		sb_q[0] <= '{req_type: cmd.req_type, rotation: cmd.rotation,
			orbit_radius: cmd.orbit_radius};
		for (int i = 1; i < fwdm_pkg::LANE_LAT; i++)
			sb_q[i] <= sb_q[i-1];
	end

	// Scale by base speed; the shift truncates the magnitude, so the signed value
	// rounds toward zero.
	assign prod_m = (fwdm_pkg::SIN_W+8)'(sine_m.mag) * (fwdm_pkg::SIN_W+8)'(base_speed_q);
	assign prod_p = (fwdm_pkg::SIN_W+8)'(sine_p.mag) * (fwdm_pkg::SIN_W+8)'(base_speed_q);

	always_ff @(posedge clk) begin
		mag_m_s18 <= prod_m[fwdm_pkg::SINE_FRAC_BITS+7:fwdm_pkg::SINE_FRAC_BITS];
		mag_p_s18 <= prod_p[fwdm_pkg::SINE_FRAC_BITS+7:fwdm_pkg::SINE_FRAC_BITS];
		neg_m_s18 <= sine_m.neg;
		neg_p_s18 <= sine_p.neg;
		side_s18  <= sb_q[fwdm_pkg::LANE_LAT-1];
	end

	// Wheel mixing. Move mode: wheel j takes slot (j - rotation); odd slots use the
	// plus-angle sine, slots 0 and 3 are negated. A zero value always reads forward.
	always_comb begin
		logic [1:0]         slot;
		logic [7:0]         mag;
		logic               neg;
		logic signed [10:0] dx;
		logic signed [10:0] v;
		logic [10:0]        a;
		mix = '0;
		dx  = 11'(fwdm_pkg::SPIN_OFFSET) - 11'(side_s18.orbit_radius);
		for (int j = 0; j < 4; j++) begin
			slot = 2'(j) - side_s18.rotation;
			mag  = slot[0] ? mag_p_s18 : mag_m_s18;
			neg  = (slot[0] ? neg_p_s18 : neg_m_s18) ^ ~(slot[0] ^ slot[1]);
			v    = (j < 2) ? dx + 11'(spin_speed_q) : dx - 11'(spin_speed_q);
			a    = v[10] ? 11'(-v) : 11'(v);
			if (side_s18.req_type) begin
				mix.duty[j] = (a > 11'd255) ? 8'd255 : a[7:0];
				mix.fwd[j]  = ~v[10];
			end else begin
				mix.duty[j] = mag;
				mix.fwd[j]  = ~(neg && (mag != 8'd0));
			end
		end
	end

	// Result queue; the request counter keeps it from overflowing.
	always_ff @(posedge clk) begin
		if (valid_s18)
			fifo_q[wr_ptr_q[fwdm_pkg::PTR_W-1:0]] <= mix;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (valid_s18)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (accept && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (!accept && pop)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	assign fill      = wr_ptr_q - rd_ptr_q;
	assign rd_res    = fifo_q[rd_ptr_q[fwdm_pkg::PTR_W-1:0]];
	assign res.valid = wr_ptr_q != rd_ptr_q;
	assign res.duty_0 = rd_res.duty[0];
	assign res.duty_1 = rd_res.duty[1];
	assign res.duty_2 = rd_res.duty[2];
	assign res.duty_3 = rd_res.duty[3];
	assign res.fwd_0  = rd_res.fwd[0];
	assign res.fwd_1  = rd_res.fwd[1];
	assign res.fwd_2  = rd_res.fwd[2];
	assign res.fwd_3  = rd_res.fwd[3];

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= fwdm_pkg::CNT_W'(fwdm_pkg::FIFO_DEPTH))
		else $error("request count exceeds queue depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s18 |-> fill != (fwdm_pkg::PTR_W+1)'(fwdm_pkg::FIFO_DEPTH))
		else $error("result written into a full queue");

	a_fill_le_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		fwdm_pkg::CNT_W'(fill) <= cnt_q)
		else $error("queue holds more results than open requests");

	a_cnt_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !pop) |=> cnt_q == fwdm_pkg::CNT_W'($past(cnt_q) + 1'b1))
		else $error("request count missed an accepted request");

endmodule

// File: sv/fwdm_cell.sv
// One series cell: t <= 1 - (x2 * t) / d over two pipeline stages.
module fwdm_cell (
	input  logic            clk,
	input  fwdm_pkg::term_t term_in,
	input  logic [32:0]     recip,
	input  logic [5:0]      rshift,
	output fwdm_pkg::term_t term_out
);

	logic [62:0]     prod1;
	logic [31:0]     p_s1;
	fwdm_pkg::term_t term_s1;
	logic [64:0]     prod2;
	logic [64:0]     quot;
	fwdm_pkg::term_t term_s2;

	assign prod1 = 63'(term_in.x2) * 63'(term_in.t);

	always_ff @(posedge clk) begin
		p_s1    <= prod1[61:30];
		term_s1 <= term_in;
	end

	// The reciprocal is exact for every 32-bit dividend, so no correction step follows.
	assign prod2 = 65'(p_s1) * 65'(recip);
	assign quot  = prod2 >> rshift;

	always_ff @(posedge clk) begin
		term_s2.neg <= term_s1.neg;
		term_s2.x   <= term_s1.x;
		term_s2.x2  <= term_s1.x2;
		term_s2.t   <= fwdm_pkg::Q30_ONE - quot[30:0];
	end

	assign term_out = term_s2;

endmodule

// File: sv/fwdm_sine_lane.sv
// Sine lane: angle reduction, radian scaling, a row of series cells and rounding.
module fwdm_sine_lane (
	input  logic                                clk,
	input  logic signed [fwdm_pkg::ANGLE_W-1:0] angle,
	output fwdm_pkg::sine_t                     sine
);

	logic signed [15:0] ang_ext;
	logic signed [15:0] red;
	logic [12:0]        t_s1;
	logic               neg_c;
	logic [12:0]        u_fold;
	logic [12:0]        u_c;
	logic [10:0]        u_s2;
	logic               neg_s2;
	logic [41:0]        xprod;
	logic [30:0]        x_s3;
	logic               neg_s3;
	logic [61:0]        sq;
	fwdm_pkg::term_t    term_s4;
	fwdm_pkg::term_t    chain [fwdm_pkg::TAYLOR_TERMS+1];
	logic [61:0]        sprod;
	logic [31:0]        s_raw;
	logic [31:0]        s_cl;
	logic [31:0]        s_rnd;
	fwdm_pkg::sine_t    sine_s17;

	assign ang_ext = {angle[fwdm_pkg::ANGLE_W-1], angle};

	// True modulo of a full turn; the input range needs at most two turns.
	always_comb begin
		if (ang_ext < -16'(fwdm_pkg::FULL_TURN))
			red = ang_ext + 16'(2 * fwdm_pkg::FULL_TURN);
		else if (ang_ext < 16'sd0)
			red = ang_ext + 16'(fwdm_pkg::FULL_TURN);
		else if (ang_ext >= 16'(fwdm_pkg::FULL_TURN))
			red = ang_ext - 16'(fwdm_pkg::FULL_TURN);
		else
			red = ang_ext;
	end

	always_ff @(posedge clk) begin
		t_s1 <= red[12:0];
	end

	always_comb begin
		neg_c  = t_s1 >= 13'(fwdm_pkg::HALF_TURN);
		u_fold = neg_c ? t_s1 - 13'(fwdm_pkg::HALF_TURN) : t_s1;
		u_c    = (u_fold > 13'(fwdm_pkg::QUARTER_TURN)) ?
			13'(fwdm_pkg::HALF_TURN) - u_fold : u_fold;
	end

	always_ff @(posedge clk) begin
		u_s2   <= u_c[10:0];
		neg_s2 <= neg_c;
	end

	assign xprod = 42'(u_s2) * 42'(fwdm_pkg::RAD_PER_UNIT_Q40) + 42'd512;

	always_ff @(posedge clk) begin
		x_s3   <= xprod[40:10];
		neg_s3 <= neg_s2;
	end

	assign sq = 62'(x_s3) * 62'(x_s3);

	always_ff @(posedge clk) begin
		term_s4.neg <= neg_s3;
		term_s4.x   <= x_s3;
		term_s4.x2  <= sq[61:30];
		term_s4.t   <= fwdm_pkg::Q30_ONE;
	end

	assign chain[0] = term_s4;

	for (genvar k = 0; k < fwdm_pkg::TAYLOR_TERMS; k++) begin : g_cell
		fwdm_cell u_cell (
			.clk     (clk),
			.term_in (chain[k]),
			.recip   (fwdm_pkg::RECIP[k]),
			.rshift  (fwdm_pkg::RSHIFT[k]),
			.term_out(chain[k+1])
		);
	end

	assign sprod = 62'(chain[fwdm_pkg::TAYLOR_TERMS].x) * 62'(chain[fwdm_pkg::TAYLOR_TERMS].t);
	assign s_raw = sprod[61:30];
	assign s_cl  = (s_raw > 32'(fwdm_pkg::Q30_ONE)) ? 32'(fwdm_pkg::Q30_ONE) : s_raw;
	assign s_rnd = s_cl + fwdm_pkg::SINE_RND;

	always_ff @(posedge clk) begin
		sine_s17.neg <= chain[fwdm_pkg::TAYLOR_TERMS].neg;
		sine_s17.mag <= s_rnd[30:30-fwdm_pkg::SINE_FRAC_BITS];
	end

	assign sine = sine_s17;

endmodule
